// ===== src/lree_pkg.sv =====
// Package with shared types, character codes and saturation helpers for the evaluator.
`default_nettype none
package lree_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MUL,
        BK_MACC,
        BK_MSAT,
        BK_DIV,
        BK_DSAT,
        BK_END
    } back_state_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] number;
        logic        num_ovf;
        logic        last;
    } cmd_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

    function automatic logic [63:0] magnitude(input logic [63:0] v);
        magnitude = v[63] ? (64'd0 - v) : v;
    endfunction

    // Returns {overflow, value}.
    function automatic logic [64:0] sat_mag(input logic [127:0] mag, input logic neg);
        logic big;
        big = (mag[127:64] != 64'd0);
        if (neg) begin
            if (big || (mag[63:0] > MIN_NEG)) begin
                sat_mag = {1'b1, MIN_NEG};
            end
            else begin
                sat_mag = {1'b0, 64'd0 - mag[63:0]};
            end
        end
        else begin
            if (big || (mag[63:0] > MAX_POS)) begin
                sat_mag = {1'b1, MAX_POS};
            end
            else begin
                sat_mag = {1'b0, mag[63:0]};
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/lree_front.sv =====
// Front end: accepts characters, builds numbers and issues operation commands.
`default_nettype none
module lree_front #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    char_code,
    input  wire logic          last_char,
    input  wire logic          push,
    output logic               full,
    input  wire logic          q_full,
    output logic               q_push,
    output lree_pkg::cmd_t     q_wdata
);

    logic [63:0]     num_reg, num_next;
    logic            novf_reg, novf_next;
    lree_pkg::op_t   pend_reg, pend_next;
    logic            tail_reg, tail_next;
    lree_pkg::op_t   tail_op_reg, tail_op_next;

    logic            accept;
    logic            is_digit;
    logic            is_op;
    lree_pkg::op_t   char_op;
    logic [3:0]      digit_val;
    logic [63:0]     add_val;
    logic [67:0]     digit_sum;
    logic            dovf;
    logic [63:0]     dig_number;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            num_reg     <= '0;
            novf_reg    <= 1'b0;
            pend_reg    <= lree_pkg::OP_ADD;
            tail_reg    <= 1'b0;
            tail_op_reg <= lree_pkg::OP_ADD;
        end
        else begin
            num_reg     <= num_next;
            novf_reg    <= novf_next;
            pend_reg    <= pend_next;
            tail_reg    <= tail_next;
            tail_op_reg <= tail_op_next;
        end
    end

    always_comb begin
        is_op   = 1'b1;
        char_op = lree_pkg::OP_ADD;
        case (char_code)
            lree_pkg::CH_PLUS:  char_op = lree_pkg::OP_ADD;
            lree_pkg::CH_MINUS: char_op = lree_pkg::OP_SUB;
            lree_pkg::CH_STAR:  char_op = lree_pkg::OP_MUL;
            lree_pkg::CH_SLASH: char_op = lree_pkg::OP_DIV;
            default:            is_op   = 1'b0;
        endcase
    end

    assign is_digit   = (char_code >= lree_pkg::CH_ZERO) && (char_code <= lree_pkg::CH_NINE);
    assign digit_val  = 4'(char_code - lree_pkg::CH_ZERO);
    assign add_val    = 64'(digit_val) << FRACTION_BITS;
    assign digit_sum  = (68'(num_reg) << 3) + (68'(num_reg) << 1) + 68'(add_val);
    assign dovf       = (digit_sum[67:63] != 5'd0);
    assign dig_number = dovf ? lree_pkg::MAX_POS : digit_sum[63:0];

    assign full   = q_full || tail_reg;
    assign accept = push && !full;

    always_comb begin
        num_next     = num_reg;
        novf_next    = novf_reg;
        pend_next    = pend_reg;
        tail_next    = tail_reg;
        tail_op_next = tail_op_reg;
        q_push       = 1'b0;
        q_wdata      = '{op: pend_reg, number: num_reg, num_ovf: novf_reg, last: 1'b1};

        if (tail_reg) begin
            if (!q_full) begin
                q_push    = 1'b1;
                q_wdata   = '{op: tail_op_reg, number: 64'd0, num_ovf: 1'b0, last: 1'b1};
                tail_next = 1'b0;
                pend_next = lree_pkg::OP_ADD;
            end
        end
        else if (accept) begin
            if (is_digit) begin
                if (last_char) begin
                    q_push    = 1'b1;
                    q_wdata   = '{op: pend_reg, number: dig_number,
                                  num_ovf: novf_reg | dovf, last: 1'b1};
                    num_next  = '0;
                    novf_next = 1'b0;
                    pend_next = lree_pkg::OP_ADD;
                end
                else begin
                    num_next  = dig_number;
                    novf_next = novf_reg | dovf;
                end
            end
            else if (is_op) begin
                q_push    = 1'b1;
                q_wdata   = '{op: pend_reg, number: num_reg, num_ovf: novf_reg, last: 1'b0};
                num_next  = '0;
                novf_next = 1'b0;
                if (last_char) begin
                    tail_next    = 1'b1;
                    tail_op_next = char_op;
                end
                else begin
                    pend_next = char_op;
                end
            end
            else if (last_char) begin
                q_push    = 1'b1;
                num_next  = '0;
                novf_next = 1'b0;
                pend_next = lree_pkg::OP_ADD;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/lree_cmd_queue.sv =====
// Command queue between the front end and the arithmetic back end.
`default_nettype none
module lree_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire lree_pkg::cmd_t wr_data,
    input  wire logic           rd_en,
    output lree_pkg::cmd_t      rd_data,
    output logic                q_full,
    output logic                q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lree_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign q_full  = (count_reg == (AW+1)'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    overflow_chk: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !wr_en || rd_en)
        else $error("command written into a full queue");

    underflow_chk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !q_empty)
        else $error("command taken from an empty queue");

endmodule
`default_nettype wire

// ===== src/lree_back.sv =====
// Back end: fixed point add, subtract, multiply and divide with saturation, and result register.
`default_nettype none
module lree_back #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lree_pkg::cmd_t head,
    input  wire logic           q_empty,
    output logic                q_pop,
    output logic [63:0]         result_value,
    output logic [1:0]          status,
    output logic                empty,
    input  wire logic           pop
);

    localparam int QW = 64 + FRACTION_BITS;
    localparam int CW = $clog2(QW);

    lree_pkg::back_state_t state_reg, state_next;
    logic [63:0]  acc_reg, acc_next;
    logic         div0_reg, div0_next;
    logic         ovf_reg, ovf_next;
    logic [63:0]  mag_a_reg, mag_a_next;
    logic [63:0]  mag_b_reg, mag_b_next;
    logic         neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0]  prod_reg, prod_next;
    logic [127:0] wide_reg, wide_next;
    logic [QW-1:0] dq_reg, dq_next;
    logic [63:0]  rem_reg, rem_next;
    logic         out_valid_reg, out_valid_next;
    logic [63:0]  out_value_reg, out_value_next;
    lree_pkg::status_t out_status_reg, out_status_next;

    logic         emit;
    logic [64:0]  exact;
    logic [64:0]  sat;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [127:0] part;
    logic [63:0]  shifted;
    logic         ge;

    assign mul_a   = cnt_reg[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign mul_b   = cnt_reg[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];
    assign shifted = {rem_reg[62:0], dq_reg[QW-1]};
    assign ge      = (shifted >= mag_b_reg);

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    part = 128'(prod_reg);
            2'd3:    part = 128'(prod_reg) << 64;
            default: part = 128'(prod_reg) << 32;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        div0_next       = div0_reg;
        ovf_next        = ovf_reg;
        mag_a_next      = mag_a_reg;
        mag_b_next      = mag_b_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        wide_next       = wide_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        exact           = '0;
        sat             = '0;

        case (state_reg)
            lree_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = lree_pkg::BK_EXEC;
                end
            end
            lree_pkg::BK_EXEC:
            begin
                ovf_next   = ovf_reg | head.num_ovf;
                mag_a_next = lree_pkg::magnitude(acc_reg);
                mag_b_next = lree_pkg::magnitude(head.number);
                neg_next   = acc_reg[63] ^ head.number[63];
                cnt_next   = '0;
                case (head.op)
                    lree_pkg::OP_ADD, lree_pkg::OP_SUB:
                    begin
                        if (head.op == lree_pkg::OP_SUB)
                        begin
                            exact = {acc_reg[63], acc_reg} - {head.number[63], head.number};
                        end
                        else
                        begin
                            exact = {acc_reg[63], acc_reg} + {head.number[63], head.number};
                        end
                        if (exact[64] != exact[63])
                        begin
                            ovf_next = 1'b1;
                            acc_next = exact[64] ? lree_pkg::MIN_NEG : lree_pkg::MAX_POS;
                        end
                        else
                        begin
                            acc_next = exact[63:0];
                        end
                        state_next = lree_pkg::BK_END;
                    end
                    lree_pkg::OP_MUL:
                    begin
                        wide_next  = '0;
                        state_next = lree_pkg::BK_MUL;
                    end
                    default:
                    begin
                        if (head.number == 64'd0)
                        begin
                            div0_next  = 1'b1;
                            state_next = lree_pkg::BK_END;
                        end
                        else
                        begin
                            dq_next    = QW'(lree_pkg::magnitude(acc_reg)) << FRACTION_BITS;
                            rem_next   = '0;
                            state_next = lree_pkg::BK_DIV;
                        end
                    end
                endcase
            end
            lree_pkg::BK_MUL:
            begin
                prod_next  = 64'(mul_a) * 64'(mul_b);
                state_next = lree_pkg::BK_MACC;
            end
            lree_pkg::BK_MACC:
            begin
                wide_next = wide_reg + part;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = lree_pkg::BK_MSAT;
                end
                else
                begin
                    state_next = lree_pkg::BK_MUL;
                end
            end
            lree_pkg::BK_MSAT:
            begin
                sat        = lree_pkg::sat_mag(wide_reg >> FRACTION_BITS, neg_reg);
                acc_next   = sat[63:0];
                ovf_next   = ovf_reg | sat[64];
                state_next = lree_pkg::BK_END;
            end
            lree_pkg::BK_DIV:
            begin
                rem_next = ge ? (shifted - mag_b_reg) : shifted;
                dq_next  = {dq_reg[QW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(QW - 1))
                begin
                    state_next = lree_pkg::BK_DSAT;
                end
            end
            lree_pkg::BK_DSAT:
            begin
                sat        = lree_pkg::sat_mag(128'(dq_reg), neg_reg);
                acc_next   = sat[63:0];
                ovf_next   = ovf_reg | sat[64];
                state_next = lree_pkg::BK_END;
            end
            lree_pkg::BK_END:
            begin
                if (!head.last)
                begin
                    q_pop      = 1'b1;
                    state_next = lree_pkg::BK_IDLE;
                end
                else if (!out_valid_reg || pop)
                begin
                    q_pop          = 1'b1;
                    emit           = 1'b1;
                    out_value_next = div0_reg ? 64'd0 : acc_reg;
                    if (div0_reg)
                    begin
                        out_status_next = lree_pkg::ST_DIV0;
                    end
                    else if (ovf_reg)
                    begin
                        out_status_next = lree_pkg::ST_OVF;
                    end
                    else
                    begin
                        out_status_next = lree_pkg::ST_OK;
                    end
                    acc_next   = '0;
                    div0_next  = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = lree_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lree_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lree_pkg::BK_IDLE;
            acc_reg       <= '0;
            div0_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            div0_reg      <= div0_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg      <= mag_a_next;
        mag_b_reg      <= mag_b_next;
        neg_reg        <= neg_next;
        cnt_reg        <= cnt_next;
        prod_reg       <= prod_next;
        wide_reg       <= wide_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign result_value = out_value_reg;
    assign status       = out_status_reg;
    assign empty        = !out_valid_reg;

    emit_last_chk: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> head.last && !q_empty)
        else $error("result emitted for a command that does not end the expression");

    emit_clear_chk: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (acc_reg == 64'd0) && !div0_reg && !ovf_reg)
        else $error("evaluation state not cleared after a result");

    div_nonzero_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lree_pkg::BK_DIV) |-> (mag_b_reg != 64'd0))
        else $error("divider running with a zero divisor");

    no_overwrite_chk: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || pop)
        else $error("waiting result overwritten");

endmodule
`default_nettype wire

// ===== src/left_to_right_expression_evaluator_unit.sv =====
// Top level of the left to right expression evaluator.
// Sequencing: each command passes the idle and execute states; an add, subtract or division by
// zero then ends, while a multiply loops multiply-accumulate steps and a divide loops quotient
// bit steps before a saturation step; a result beat is offered when the final command ends.
// Throughput: one character per cycle while the queue has room and no final operator waits.
// Reset: rst_n clears the evaluation state and empties the queue and the result register.
`default_nettype none
module left_to_right_expression_evaluator_unit #(
    parameter int FRACTION_BITS = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         char_code,
    input  wire logic               last_char,
    input  wire logic               push,
    output logic                    full,
    output logic signed [63:0]      result_value,
    output logic [1:0]              status,
    output logic                    empty,
    input  wire logic               pop
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    lree_pkg::cmd_t q_wdata;
    lree_pkg::cmd_t q_head;
    logic [63:0]    value;

    lree_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .last_char (last_char),
        .push      (push),
        .full      (full),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    lree_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    lree_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .result_value (value),
        .status       (status),
        .empty        (empty),
        .pop          (pop)
    );

    assign result_value = $signed(value);

endmodule
`default_nettype wire
